FILE: sv/unsorted_table_engine_assert.svh
// Assertion macros for the checker file of the unsorted table engine.
`ifndef UNSORTED_TABLE_ENGINE_ASSERT_SVH
`define UNSORTED_TABLE_ENGINE_ASSERT_SVH

// Check a property on every rising edge of clk_i outside reset.
`define UTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define UTE_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

FILE: sv/ute_pkg.sv
// Shared types, codes and constants of the unsorted table engine.
`default_nettype none

package ute_pkg;

  localparam int unsigned DEPTH_DEF   = 1024;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned FOUND_IDX_W = 10;
  localparam int unsigned ENTRY_CNT_W = 11;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned M_TDATA_W   = 88;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_MINMAX = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_SHIFT  = 2'd2,
    S_FINISH = 2'd3
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic match;
    logic scan_done;
    logic shift_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/unsorted_table_engine.sv
// Top level of the unsorted table engine: stream ports, controller and datapath.
// Insert and any request on an empty table go from idle straight to finish; search and
//   min-max scan first; delete scans, then shifts on a match.
// One request at a time, the next taken in the cycle after the result loads;
//   one table read per cycle sets the scan and shift length.
// Reset clears the entry count and the handshake state; table contents stay undefined.
`default_nettype none

module unsorted_table_engine
  import ute_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Request stream
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] op, [33:2] value, [39:34] zero
  input  wire  [S_TDATA_W-1:0] s_axis_tdata,
  // Result stream
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // [1:0] status, [11:2] found_index, [43:12] min_value, [75:44] max_value,
  // [86:76] entry_count, [87] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  ctrl_cmd_t                 cmd;
  dp_status_t                stat;
  op_e                       in_op;
  logic signed [VALUE_W-1:0] in_value;
  stat_e                     status;
  logic [FOUND_IDX_W-1:0]    found_index;
  logic signed [VALUE_W-1:0] min_value, max_value;
  logic [ENTRY_CNT_W-1:0]    entry_count;

  // Unpack the request; the pad bits above value are ignored.
  assign in_op    = op_e'(s_axis_tdata[1:0]);
  assign in_value = s_axis_tdata[VALUE_W+1:2];

  // Sequencer: accept in idle, scan, shift on a delete hit, load the result register.
  ute_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (in_op),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // Table memory, scan compare stage, count and result register.
  ute_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_op_i       (in_op),
    .in_value_i    (in_value),
    .stat_o        (stat),
    .status_o      (status),
    .found_index_o (found_index),
    .min_value_o   (min_value),
    .max_value_o   (max_value),
    .entry_count_o (entry_count)
  );

  // Pack the result, lowest field first, pad to whole bytes.
  assign m_axis_tdata = {1'b0, entry_count, max_value, min_value, found_index, status};

endmodule

`default_nettype wire

FILE: sv/ute_ctrl.sv
// Controller state machine of the unsorted table engine.
`default_nettype none

module ute_ctrl
  import ute_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  op_e        in_op_i,
  input  wire        out_ready_i,
  input  dp_status_t stat_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_INSERT || stat_i.empty) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.op == OP_DELETE && stat_i.match) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      S_SCAN:  cmd_o.scan  = 1'b1;
      S_SHIFT: cmd_o.shift = 1'b1;
      S_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/ute_datapath.sv
// Datapath of the unsorted table engine: table memory, scan pipeline, result register.
`default_nettype none

module ute_datapath
  import ute_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  input  op_e                       in_op_i,
  input  wire  signed [VALUE_W-1:0] in_value_i,
  output dp_status_t                stat_o,
  output stat_e                     status_o,
  output logic [FOUND_IDX_W-1:0]    found_index_o,
  output logic signed [VALUE_W-1:0] min_value_o,
  output logic signed [VALUE_W-1:0] max_value_o,
  output logic [ENTRY_CNT_W-1:0]    entry_count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [VALUE_W-1:0] mem_q [DEPTH];

  op_e                       op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          ptr_q, ptr_d;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic signed [VALUE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]          hit_idx_q;
  logic                      found_q;
  logic signed [VALUE_W-1:0] min_q, max_q;

  stat_e                     status_q;
  logic [FOUND_IDX_W-1:0]    found_index_q;
  logic signed [VALUE_W-1:0] min_out_q, max_out_q;
  logic [ENTRY_CNT_W-1:0]    entry_count_q;

  logic                      empty, full, eq, match, stage_last;
  logic                      scan_done, shift_done, issue;
  logic [CNT_W-1:0]          last_idx;
  logic                      we;
  logic [IDX_W-1:0]          wr_addr;
  logic [VALUE_W-1:0]        wr_data;
  stat_e                     status_d;
  logic [IDX_W+FOUND_IDX_W-1:0] hit_ext;
  logic [CNT_W+ENTRY_CNT_W-1:0] cnt_ext;

  assign empty      = (count_q == '0);
  assign full       = (count_q == DEPTH_C);
  assign last_idx   = count_q - 1'b1;
  assign eq         = (rd_data_q == value_q);
  assign match      = rd_vld_q && eq && (op_q != OP_MINMAX);
  assign stage_last = rd_vld_q && (CNT_W'(rd_idx_q) == last_idx);
  assign scan_done  = match || stage_last;
  assign shift_done = (CNT_W'(hit_idx_q) == last_idx) || stage_last;
  assign issue      = ((cmd_i.scan && !scan_done) || (cmd_i.shift && !shift_done))
                      && (ptr_q < count_q);

  assign stat_o = '{op: op_q, empty: empty, match: match,
                    scan_done: scan_done, shift_done: shift_done};

  // Table memory: one write port, one registered read port.
  always_comb begin
    we      = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = value_q;
    if (cmd_i.finish && op_q == OP_INSERT && !full) begin
      we = 1'b1;
    end else if (cmd_i.shift && rd_vld_q) begin
      we      = 1'b1;
      wr_addr = rd_idx_q - 1'b1;
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[ptr_q[IDX_W-1:0]];
    rd_idx_q  <= ptr_q[IDX_W-1:0];
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.scan && scan_done) begin
      ptr_d = CNT_W'(rd_idx_q) + 1'b1;
    end else if (issue) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = STAT_OK;
    if (op_q == OP_INSERT) begin
      if (full) begin
        status_d = STAT_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (empty) begin
      status_d = STAT_EMPTY;
    end else if (op_q != OP_MINMAX) begin
      if (!found_q) begin
        status_d = STAT_NOT_FOUND;
      end else if (op_q == OP_DELETE) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  assign hit_ext = (IDX_W + FOUND_IDX_W)'(hit_idx_q);
  assign cnt_ext = (CNT_W + ENTRY_CNT_W)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      value_q <= in_value_i;
      found_q <= 1'b0;
    end
    // Keep the first match only; the scan stops on it.
    if (cmd_i.scan && match) begin
      hit_idx_q <= rd_idx_q;
      found_q   <= 1'b1;
    end
    if (cmd_i.scan && rd_vld_q && op_q == OP_MINMAX) begin
      if (rd_idx_q == '0) begin
        min_q <= rd_data_q;
        max_q <= rd_data_q;
      end else begin
        if (rd_data_q < min_q) min_q <= rd_data_q;
        if (rd_data_q > max_q) max_q <= rd_data_q;
      end
    end
    if (cmd_i.finish) begin
      status_q      <= status_d;
      found_index_q <= '0;
      min_out_q     <= '0;
      max_out_q     <= '0;
      entry_count_q <= cnt_ext[ENTRY_CNT_W-1:0];
      if (status_d == STAT_OK && op_q == OP_SEARCH) begin
        found_index_q <= hit_ext[FOUND_IDX_W-1:0];
      end
      if (status_d == STAT_OK && op_q == OP_MINMAX) begin
        min_out_q <= min_q;
        max_out_q <= max_q;
      end
    end
  end

  assign status_o      = status_q;
  assign found_index_o = found_index_q;
  assign min_value_o   = min_out_q;
  assign max_value_o   = max_out_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

FILE: sv/ute_checker.sv
// Port-level assertions for the unsorted table engine, bound to the top level.
`default_nettype none
`include "unsorted_table_engine_assert.svh"

module ute_checker
  import ute_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 s_axis_tvalid,
  input wire                 s_axis_tready,
  input wire                 m_axis_tvalid,
  input wire                 m_axis_tready,
  input wire [M_TDATA_W-1:0] m_axis_tdata
);

  logic                      in_xfer, out_stall, empty_res;
  stat_e                     res_status;
  logic signed [VALUE_W-1:0] res_min, res_max;
  logic [ENTRY_CNT_W-1:0]    res_count;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign res_status = stat_e'(m_axis_tdata[1:0]);
  assign res_min    = m_axis_tdata[43:12];
  assign res_max    = m_axis_tdata[75:44];
  assign res_count  = m_axis_tdata[86:76];
  assign empty_res  = m_axis_tvalid && (res_status == STAT_EMPTY);

  `UTE_ASSERT(a_valid_holds, out_stall |=> m_axis_tvalid, "result dropped while stalled")
  `UTE_ASSERT_HOLD(a_data_holds, out_stall, m_axis_tdata, "result changed while stalled")
  `UTE_ASSERT(a_busy_after_accept, in_xfer |=> !s_axis_tready, "request taken while busy")
  `UTE_ASSERT(a_min_le_max, m_axis_tvalid |-> (res_min <= res_max), "minimum above maximum")
  `UTE_ASSERT(a_empty_count, empty_res |-> (res_count == '0), "empty status with entries")

endmodule

bind unsorted_table_engine ute_checker u_ute_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/tb_unsorted_table_engine.sv
// Self-checking stream testbench for the unsorted table engine.
`timescale 1ns / 100ps

module tb_unsorted_table_engine;
  import ute_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEPTH_DEF;
  // Longest correct item: a delete on a full table, whose scan and shift together cover the whole table.
  localparam int unsigned ITEM_CYCLES = 2 * TABLE_DEPTH + 16;
  // Cycles with no transfer on either side before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4 * ITEM_CYCLES + 4000;
  // Long receiver hold-off that makes the block back up into its input.
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 145;
  localparam int unsigned MAX_REPORTS = 10;

  // One result transfer, unpacked into its fields.
  typedef struct {
    stat_e              status;
    logic [9:0]         idx;
    logic signed [31:0] min_v;
    logic signed [31:0] max_v;
    logic [10:0]        count;
  } reply_t;

  // One row of the directed table; a fixed row carries its reply typed in.
  typedef struct {
    op_e         op;
    logic [31:0] value;
    bit          fixed;
    reply_t      reply;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [1:0] op, [33:2] value, [39:34] zero
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [1:0] status, [11:2] found_index, [43:12] min_value, [75:44] max_value,
  // [86:76] entry_count, [87] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the table contents; its size is the entry count.
  logic signed [31:0] stored_values[$];
  // Replies owed by the block, oldest first.
  reply_t             pending_replies[$];
  stim_row_t          directed_rows[$];
  logic [31:0]        hot_values[8];

  int unsigned req_gap_pct = 0;
  int unsigned reply_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned fail_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  unsorted_table_engine #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Apply one request to the shadow table and return the reply it earns.
  function automatic reply_t apply_request(op_e op, logic signed [31:0] v);
    reply_t r;
    int     hit;
    r.status = STAT_OK;
    r.idx    = '0;
    r.min_v  = '0;
    r.max_v  = '0;
    hit      = -1;
    if (op == OP_INSERT) begin
      // Refuse the append once every slot is taken.
      if (stored_values.size() >= TABLE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        stored_values.insert(stored_values.size(), v);
      end
    end else if (stored_values.size() == 0) begin
      r.status = STAT_EMPTY;
    end else if (op == OP_MINMAX) begin
      r.min_v = stored_values[0];
      r.max_v = stored_values[0];
      foreach (stored_values[i]) begin
        if (stored_values[i] < r.min_v) r.min_v = stored_values[i];
        if (stored_values[i] > r.max_v) r.max_v = stored_values[i];
      end
    end else begin
      // Delete and search both act on the first match only.
      foreach (stored_values[i]) begin
        if (hit < 0 && stored_values[i] == v) hit = i;
      end
      if (hit < 0) begin
        r.status = STAT_NOT_FOUND;
      end else if (op == OP_SEARCH) begin
        r.idx = hit[9:0];
      end else begin
        stored_values.delete(hit);
      end
    end
    r.count = 11'(stored_values.size());
    return r;
  endfunction

  task automatic add_row(op_e op, logic [31:0] v, bit fixed, stat_e st,
                         logic [9:0] idx, logic [31:0] mn, logic [31:0] mx,
                         logic [10:0] cnt);
    stim_row_t row;
    row.op           = op;
    row.value        = v;
    row.fixed        = fixed;
    row.reply.status = st;
    row.reply.idx    = idx;
    row.reply.min_v  = mn;
    row.reply.max_v  = mx;
    row.reply.count  = cnt;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offer one request, starting at a falling edge, and return at the falling
  // edge after its transfer. The task sets tvalid only at falling edges.
  task automatic send_request(op_e op, logic [31:0] v, bit fixed, reply_t fixed_reply);
    reply_t want;
    while ($urandom_range(99) < req_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // Transfer taken: update the shadow table even when the reply is typed in.
    want = apply_request(op, v);
    if (fixed) want = fixed_reply;
    pending_replies.insert(pending_replies.size(), want);
    @(negedge clk_i);
  endtask

  // Plain request whose reply comes from the shadow table alone.
  task automatic send_op(op_e op, logic [31:0] v);
    reply_t unused;
    unused = '{STAT_OK, '0, '0, '0, '0};
    send_request(op, v, 1'b0, unused);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= reply_stall_pct);
    end
  end

  // Compare every result transfer with the oldest reply owed.
  always @(posedge clk_i) begin : reply_check
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = stat_e'(m_axis_tdata[1:0]);
      got.idx    = m_axis_tdata[11:2];
      got.min_v  = m_axis_tdata[43:12];
      got.max_v  = m_axis_tdata[75:44];
      got.count  = m_axis_tdata[86:76];
      if (pending_replies.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result transfer, data %h", $realtime, m_axis_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.idx !== want.idx ||
            got.min_v !== want.min_v || got.max_v !== want.max_v ||
            got.count !== want.count) begin
          fail_cnt++;
          mismatch_cnt++;
          // Fields in order: status, index, min, max, count.
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     $realtime,
                     want.status, want.idx, want.min_v, want.max_v, want.count,
                     got.status, got.idx, got.min_v, got.max_v, got.count);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("tb_unsorted_table_engine failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned cap;
    int unsigned pick;
    int unsigned ins_pct;
    op_e         op;
    logic [31:0] v;

    hot_values[0] = 32'h0000_0000;
    hot_values[1] = 32'hFFFF_FFFF;
    hot_values[2] = 32'h8000_0000;
    hot_values[3] = 32'h7FFF_FFFF;
    for (int k = 4; k < 8; k++) hot_values[k] = $urandom;

    // Directed part. Empty table first, then the extremes of the value field,
    // duplicates for first-match behavior, and a walk back down to empty.
    add_row(OP_SEARCH, 32'd5,          1, STAT_EMPTY,     0, 0, 0, 0);
    add_row(OP_DELETE, 32'd5,          1, STAT_EMPTY,     0, 0, 0, 0);
    add_row(OP_MINMAX, 32'hFFFF_FFFF,  1, STAT_EMPTY,     0, 0, 0, 0);
    add_row(OP_INSERT, 32'h7FFF_FFFF,  1, STAT_OK,        0, 0, 0, 1);
    add_row(OP_INSERT, 32'h8000_0000,  1, STAT_OK,        0, 0, 0, 2);
    add_row(OP_MINMAX, 32'h0000_0000,  1, STAT_OK,        0, 32'h8000_0000, 32'h7FFF_FFFF, 2);
    add_row(OP_INSERT, 32'hFFFF_FFFF,  1, STAT_OK,        0, 0, 0, 3);
    add_row(OP_INSERT, 32'h0000_0000,  1, STAT_OK,        0, 0, 0, 4);
    add_row(OP_INSERT, 32'h7FFF_FFFF,  1, STAT_OK,        0, 0, 0, 5);
    add_row(OP_SEARCH, 32'h7FFF_FFFF,  1, STAT_OK,        0, 0, 0, 5);
    add_row(OP_SEARCH, 32'h0000_0000,  1, STAT_OK,        3, 0, 0, 5);
    add_row(OP_SEARCH, 32'd12345,      1, STAT_NOT_FOUND, 0, 0, 0, 5);
    add_row(OP_DELETE, 32'd12345,      1, STAT_NOT_FOUND, 0, 0, 0, 5);
    add_row(OP_DELETE, 32'h7FFF_FFFF,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_SEARCH, 32'h7FFF_FFFF,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_MINMAX, 32'hDEAD_BEEF,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_DELETE, 32'h8000_0000,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_SEARCH, 32'h0000_0000,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_DELETE, 32'hFFFF_FFFF,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_DELETE, 32'h7FFF_FFFF,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_DELETE, 32'h0000_0000,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_MINMAX, 32'h5555_AAAA,  1, STAT_EMPTY,     0, 0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0001,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_MINMAX, 32'hAAAA_5555,  0, STAT_OK,        0, 0, 0, 0);
    add_row(OP_DELETE, 32'h0000_0001,  0, STAT_OK,        0, 0, 0, 0);

    // Hold reset, release it once, and start at a falling edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r])
      send_request(directed_rows[r].op, directed_rows[r].value,
                   directed_rows[r].fixed, directed_rows[r].reply);

    // Random part in four idling phases: none, sender gaps, receiver stalls,
    // both. Keep the table small so scans stay short, and steer the size
    // toward a moving cap so it also drains to empty now and then.
    cap = 8;
    for (int phase = 0; phase < 4; phase++) begin
      req_gap_pct     = (phase == 1) ? 60 : (phase == 3) ? 20 : 0;
      reply_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 20 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Stall the receiver for a long stretch while requests keep coming.
        if (phase == 0 && n == 40) hold_req++;
        if (n % 25 == 0) cap = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
        ins_pct = (stored_values.size() > cap) ? 10 :
                  (stored_values.size() < cap) ? 55 : 30;
        pick = $urandom_range(99);
        if (pick < ins_pct) begin
          op = OP_INSERT;
        end else begin
          case ($urandom_range(2))
            0:       op = OP_DELETE;
            1:       op = OP_SEARCH;
            default: op = OP_MINMAX;
          endcase
        end
        // Mostly values already stored or from a small pool, so matches and
        // duplicates are common; the rest are fully random.
        pick = $urandom_range(99);
        if (pick < 45 && stored_values.size() != 0)
          v = stored_values[$urandom_range(stored_values.size() - 1)];
        else if (pick < 75)
          v = hot_values[$urandom_range(7)];
        else
          v = $urandom;
        send_op(op, v);
      end
    end

    // Fill the table to capacity, then hit the full-table cases: a refused
    // insert, a search that lands on the last slot, a whole-table min-max,
    // a miss that scans everything, and delete and refill at the boundary.
    req_gap_pct     = 0;
    reply_stall_pct = 0;
    while (stored_values.size() < TABLE_DEPTH) send_op(OP_INSERT, $urandom);
    send_op(OP_INSERT, $urandom);
    send_op(OP_SEARCH, stored_values[TABLE_DEPTH - 1]);
    send_op(OP_SEARCH, stored_values[0]);
    send_op(OP_MINMAX, $urandom);
    send_op(OP_SEARCH, $urandom);
    send_op(OP_DELETE, stored_values[TABLE_DEPTH / 2]);
    send_op(OP_INSERT, $urandom);
    send_op(OP_INSERT, $urandom);
    send_op(OP_DELETE, stored_values[TABLE_DEPTH - 1]);
    send_op(OP_MINMAX, $urandom);
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every owed reply, then watch a while for stray results.
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (ITEM_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && pending_replies.size() == 0) begin
      $display("tb_unsorted_table_engine passed");
    end else begin
      $display("tb_unsorted_table_engine failed");
    end
    $finish;
  end

endmodule
